/* hw/rtl/hrag_pkg.sv */
// Shared types, constants and helpers for the halo region address generator.
// No dependencies; imported by every module of the block.
package hrag_pkg;

  localparam int unsigned MaxSideDefault = 64;
  localparam int unsigned RegionW        = 5;
  localparam int unsigned GridW          = 18;
  localparam int unsigned BufW           = 12;
  localparam int unsigned CfgDataW       = 7;
  localparam int unsigned CfgAddrW       = 2;
  localparam int unsigned InDataW        = 8;
  localparam int unsigned OutDataW       = 32;
  localparam int unsigned QueueDepth     = 2;

  // region codes: 26 neighbors, the center digit is skipped
  localparam logic [RegionW-1:0] RegionLast   = RegionW'(25);
  localparam logic [RegionW-1:0] RegionCenter = RegionW'(13);

  typedef enum logic [1:0] {
    AXIS_LOW  = 2'd0,
    AXIS_FULL = 2'd1,
    AXIS_HIGH = 2'd2
  } axis_sel_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SIDE_X = 2'd0,
    REG_SIDE_Y = 2'd1,
    REG_SIDE_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                bad;
    logic [RegionW-1:0]  region;
    axis_sel_e           sel_z;
    axis_sel_e           sel_y;
    axis_sel_e           sel_x;
  } item_t;

  localparam int unsigned ItemW = $bits(item_t);

  // Sides are 7-bit registers, so no side can exceed 127 whatever the cap.
  function automatic int side_cap(int max_side);
    return (max_side < 127) ? max_side : 127;
  endfunction

  function automatic int coord_w(int max_side);
    return $clog2(side_cap(max_side));
  endfunction

  function automatic int side_w(int max_side);
    return $clog2(side_cap(max_side) + 1);
  endfunction

  // Split a region code into its three base-3 axis digits.
  function automatic item_t classify(logic [RegionW-1:0] region);
    item_t              it;
    logic [RegionW-1:0] d;
    logic [RegionW-1:0] rem;
    it.bad    = (region > RegionLast);
    it.region = region;
    d = (region < RegionCenter) ? region : RegionW'(region + 1'b1);
    if (d >= RegionW'(18)) begin
      it.sel_z = AXIS_HIGH;
      rem      = RegionW'(d - RegionW'(18));
    end else if (d >= RegionW'(9)) begin
      it.sel_z = AXIS_FULL;
      rem      = RegionW'(d - RegionW'(9));
    end else begin
      it.sel_z = AXIS_LOW;
      rem      = d;
    end
    if (rem >= RegionW'(6)) begin
      it.sel_y = AXIS_HIGH;
      rem      = RegionW'(rem - RegionW'(6));
    end else if (rem >= RegionW'(3)) begin
      it.sel_y = AXIS_FULL;
      rem      = RegionW'(rem - RegionW'(3));
    end else begin
      it.sel_y = AXIS_LOW;
    end
    it.sel_x = axis_sel_e'(rem[1:0]);
    if (it.bad) begin
      it.sel_z = AXIS_LOW;
      it.sel_y = AXIS_LOW;
      it.sel_x = AXIS_LOW;
    end
    return it;
  endfunction

endpackage

/* hw/rtl/hrag_cfg.sv */
// Side registers with clamping, plane size and high-plane base offsets.
// Depends on hrag_pkg.
module hrag_cfg import hrag_pkg::*; #(
  parameter int MAX_SIDE = MaxSideDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgAddrW-1:0]           cfg_addr_i,
  input  logic [CfgDataW-1:0]           cfg_data_i,
  output logic                          wr_o,
  output logic [side_w(MAX_SIDE)-1:0]   side_x_o,
  output logic [side_w(MAX_SIDE)-1:0]   side_y_o,
  output logic [side_w(MAX_SIDE)-1:0]   side_z_o,
  output logic [GridW-1:0]              plane_o,
  output logic [GridW-1:0]              y_hi_base_o,
  output logic [GridW-1:0]              z_hi_base_o
);

  localparam int SideW = side_w(MAX_SIDE);

  logic [SideW-1:0] side_x_q, side_x_d;
  logic [SideW-1:0] side_y_q, side_y_d;
  logic [SideW-1:0] side_z_q, side_z_d;
  logic [SideW-1:0] clamped;
  logic [GridW-1:0] plane_q, plane_d;
  logic [GridW-1:0] y_hi_base_q, z_hi_base_q;
  logic             wr;
  logic             reg_hit;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    if (cfg_data_i == '0) begin
      clamped = SideW'(1);
    end else if (int'(cfg_data_i) > MAX_SIDE) begin
      clamped = SideW'(MAX_SIDE);
    end else begin
      clamped = SideW'(cfg_data_i);
    end
  end

  always_comb begin
    side_x_d = side_x_q;
    side_y_d = side_y_q;
    side_z_d = side_z_q;
    reg_hit  = 1'b0;
    if (wr) begin
      unique case (cfg_addr_i)
        REG_SIDE_X: begin
          side_x_d = clamped;
          reg_hit  = 1'b1;
        end
        REG_SIDE_Y: begin
          side_y_d = clamped;
          reg_hit  = 1'b1;
        end
        REG_SIDE_Z: begin
          side_z_d = clamped;
          reg_hit  = 1'b1;
        end
        default: ;
      endcase
    end
    plane_d = GridW'(GridW'(side_x_d) * GridW'(side_y_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_x_q    <= SideW'(1);
      side_y_q    <= SideW'(1);
      side_z_q    <= SideW'(1);
      plane_q     <= GridW'(1);
      y_hi_base_q <= '0;
      z_hi_base_q <= '0;
    end else begin
      side_x_q    <= side_x_d;
      side_y_q    <= side_y_d;
      side_z_q    <= side_z_d;
      plane_q     <= plane_d;
      // registered from the side registers, so it trails a write; the item queue covers that gap
      y_hi_base_q <= GridW'(GridW'(side_y_q - 1'b1) * GridW'(side_x_q));
      z_hi_base_q <= GridW'(GridW'(side_z_q - 1'b1) * plane_q);
    end
  end

  // of the config writes, only those to a side register close the open run
  assign wr_o        = reg_hit;
  assign side_x_o    = side_x_q;
  assign side_y_o    = side_y_q;
  assign side_z_o    = side_z_q;
  assign plane_o     = plane_q;
  assign y_hi_base_o = y_hi_base_q;
  assign z_hi_base_o = z_hi_base_q;

endmodule

/* hw/rtl/hrag_front.sv */
// Input side: takes region requests and decodes them into axis selections.
// Depends on hrag_pkg; pushes into the item queue.
module hrag_front import hrag_pkg::*; (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,   // [4:0] region, [7:5] zero
  input  logic               full_i,
  output logic               push_o,
  output item_t              item_o
);

  assign s_axis_tready = ~full_i;
  assign push_o        = s_axis_tvalid & s_axis_tready;
  assign item_o        = classify(s_axis_tdata[RegionW-1:0]);

endmodule

/* hw/rtl/hrag_fifo.sv */
// Small flop-based queue between the decode front and the address back end.
// Depends on hrag_pkg for its default width and depth.
module hrag_fifo import hrag_pkg::*; #(
  parameter int Width = ItemW,
  parameter int Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/hrag_back.sv */
// Address back end: x/y/z run counters, incremental grid index, output register.
// Depends on hrag_pkg; fed by hrag_fifo and hrag_cfg.
module hrag_back import hrag_pkg::*; #(
  parameter int MAX_SIDE = MaxSideDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  item_t                        head_i,
  output logic                         pop_o,
  input  logic                         cfg_wr_i,
  input  logic [side_w(MAX_SIDE)-1:0]  side_x_i,
  input  logic [side_w(MAX_SIDE)-1:0]  side_y_i,
  input  logic [side_w(MAX_SIDE)-1:0]  side_z_i,
  input  logic [GridW-1:0]             plane_i,
  input  logic [GridW-1:0]             y_hi_base_i,
  input  logic [GridW-1:0]             z_hi_base_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OutDataW-1:0]          m_axis_tdata,
  output logic                         m_axis_tlast
);

  localparam int CoordW = coord_w(MAX_SIDE);

  logic                active_q, active_d;
  logic [RegionW-1:0]  region_q, region_d;
  logic [CoordW-1:0]   cnt_x_q, cnt_x_d, cnt_y_q, cnt_y_d, cnt_z_q, cnt_z_d;
  logic [GridW-1:0]    base_y_q, base_y_d, base_z_q, base_z_d;
  logic [BufW-1:0]     bpos_q, bpos_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                out_last_q, out_last_d;

  logic                fire, start, last;
  logic [CoordW-1:0]   xm1, ym1, zm1;
  logic [CoordW-1:0]   x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  logic [GridW-1:0]    yb_lo, zb_lo;
  logic [CoordW-1:0]   cx, cy, cz;
  logic [GridW-1:0]    cyb, czb, idx;
  logic [BufW-1:0]     cbp;

  assign fire  = head_valid_i & (~out_valid_q | m_axis_tready);
  assign pop_o = fire;

  always_comb begin
    xm1   = CoordW'(side_x_i - 1'b1);
    ym1   = CoordW'(side_y_i - 1'b1);
    zm1   = CoordW'(side_z_i - 1'b1);
    x_lo  = (head_i.sel_x == AXIS_HIGH) ? xm1 : '0;
    x_hi  = (head_i.sel_x == AXIS_LOW)  ? '0  : xm1;
    y_lo  = (head_i.sel_y == AXIS_HIGH) ? ym1 : '0;
    y_hi  = (head_i.sel_y == AXIS_LOW)  ? '0  : ym1;
    z_lo  = (head_i.sel_z == AXIS_HIGH) ? zm1 : '0;
    z_hi  = (head_i.sel_z == AXIS_LOW)  ? '0  : zm1;
    yb_lo = (head_i.sel_y == AXIS_HIGH) ? y_hi_base_i : '0;
    zb_lo = (head_i.sel_z == AXIS_HIGH) ? z_hi_base_i : '0;

    // a new run opens when none is open or the region switches mid-run
    start = ~active_q | (head_i.region != region_q);
    cx    = start ? x_lo  : cnt_x_q;
    cy    = start ? y_lo  : cnt_y_q;
    cz    = start ? z_lo  : cnt_z_q;
    cyb   = start ? yb_lo : base_y_q;
    czb   = start ? zb_lo : base_z_q;
    cbp   = start ? '0    : bpos_q;
    idx   = GridW'(czb + cyb + GridW'(cx));
    last  = (cx == x_hi) & (cy == y_hi) & (cz == z_hi);
  end

  always_comb begin
    active_d    = active_q;
    region_d    = region_q;
    cnt_x_d     = cnt_x_q;
    cnt_y_d     = cnt_y_q;
    cnt_z_d     = cnt_z_q;
    base_y_d    = base_y_q;
    base_z_d    = base_z_q;
    bpos_d      = bpos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    if (fire) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      if (head_i.bad) begin
        active_d   = 1'b0;
        out_last_d = 1'b1;
      end else begin
        out_data_d[GridW-1:0]    = idx;
        out_data_d[GridW +: BufW] = cbp;
        out_last_d = last;
        region_d   = head_i.region;
        active_d   = ~last;
        cnt_x_d    = cx;
        cnt_y_d    = cy;
        cnt_z_d    = cz;
        base_y_d   = cyb;
        base_z_d   = czb;
        bpos_d     = BufW'(cbp + 1'b1);
        if (cx != x_hi) begin
          cnt_x_d = CoordW'(cx + 1'b1);
        end else begin
          cnt_x_d = x_lo;
          if (cy != y_hi) begin
            cnt_y_d  = CoordW'(cy + 1'b1);
            base_y_d = GridW'(cyb + GridW'(side_x_i));
          end else begin
            cnt_y_d  = y_lo;
            base_y_d = yb_lo;
            cnt_z_d  = CoordW'(cz + 1'b1);
            base_z_d = GridW'(czb + plane_i);
          end
        end
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_wr_i) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      region_q    <= '0;
      cnt_x_q     <= '0;
      cnt_y_q     <= '0;
      cnt_z_q     <= '0;
      base_y_q    <= '0;
      base_z_q    <= '0;
      bpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      region_q    <= region_d;
      cnt_x_q     <= cnt_x_d;
      cnt_y_q     <= cnt_y_d;
      cnt_z_q     <= cnt_z_d;
      base_y_q    <= base_y_d;
      base_z_q    <= base_z_d;
      bpos_q      <= bpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* hw/rtl/halo_region_address_generator.sv */
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata[4:0] region
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata[17:0] grid index, [29:18] buffer
//           |     |                              | index; tlast = end of run
// cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_addr_i register, cfg_data_i side
//
// One request per cycle sustained while m_axis_tready stays high; a taken request is written to the
// queue, then the back end loads its result into the output register, from which it leaves.
// The back end's counter/stride-add stage advances the run for each request it takes.
// Reset clears all runs and sets every side to 1. cfg_ready_o is always high.
// A stalled output holds; up to two requests wait in the queue, then s_axis_tready drops.
// Top level; depends on hrag_pkg, hrag_cfg, hrag_front, hrag_fifo and hrag_back.
module halo_region_address_generator import hrag_pkg::*; #(
  parameter int MAX_SIDE = MaxSideDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [4:0] region, [7:5] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [17:0] grid_index, [29:18] buffer_index,
                                              // [31:30] zero
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int SideW = side_w(MAX_SIDE);

  logic             cfg_wr;
  logic [SideW-1:0] side_x, side_y, side_z;
  logic [GridW-1:0] plane, y_hi_base, z_hi_base;
  logic             push, full, pop, head_valid;
  item_t            push_item, head_item;

  hrag_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .wr_o        (cfg_wr),
    .side_x_o    (side_x),
    .side_y_o    (side_y),
    .side_z_o    (side_z),
    .plane_o     (plane),
    .y_hi_base_o (y_hi_base),
    .z_hi_base_o (z_hi_base)
  );

  hrag_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  hrag_fifo #(.Width(ItemW), .Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_item)
  );

  hrag_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_item),
    .pop_o         (pop),
    .cfg_wr_i      (cfg_wr),
    .side_x_i      (side_x),
    .side_y_i      (side_y),
    .side_z_i      (side_z),
    .plane_i       (plane),
    .y_hi_base_i   (y_hi_base),
    .z_hi_base_i   (z_hi_base),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hw/rtl/hrag_checker.sv */
// Port-level checks for the halo region address generator, bound to the top level.
// Depends on hrag_pkg.
module hrag_checker import hrag_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  localparam int InflightMax = QueueDepth + 1;
  localparam int CntW        = $clog2(InflightMax + 2);

  logic            in_fire, out_fire;
  logic [CntW-1:0] inflight_q, inflight_d;
  logic            after_last_q, after_last_d;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_fire && !out_fire) begin
      inflight_d = CntW'(inflight_q + 1'b1);
    end else if (out_fire && !in_fire) begin
      inflight_d = CntW'(inflight_q - 1'b1);
    end
    after_last_d = out_fire ? m_axis_tlast : after_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q   <= '0;
      after_last_q <= 1'b1;
    end else begin
      inflight_q   <= inflight_d;
      after_last_q <= after_last_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result shown with no request outstanding");

  a_inflight_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(InflightMax))
    else $error("more requests outstanding than storage allows");

  a_run_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && after_last_q |-> m_axis_tdata[GridW +: BufW] == '0)
    else $error("run after a last element did not start at buffer position zero");

endmodule

bind halo_region_address_generator hrag_checker u_hrag_checker (.*);
